FILE: sv/fxfir_pkg.sv
// ----------------------------------------------------------------------------
// fxfir_pkg
// Shared types and constants for the fixed-point FIR filter.
// ----------------------------------------------------------------------------
package fxfir_pkg;

    localparam int MAX_TAPS_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int ACC_W        = 64;
    localparam int FRAC_BITS    = 31;
    localparam int TAPS_W       = 5;
    localparam int SLOT_W       = 4;

    localparam logic [TAPS_W-1:0] TAP_RESET = 5'd13;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic load;
    } t_cell_ctrl;

    typedef struct packed {
        logic clear;
        logic tap_en;
    } t_mac_ctrl;

endpackage

FILE: sv/fxfir_cell.sv
// ----------------------------------------------------------------------------
// fxfir_cell
// One tap cell: holds one history sample and one coefficient, shifts new
// samples along the row and rotates its pair toward the head during a pass.
// ----------------------------------------------------------------------------
module fxfir_cell
    import fxfir_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_shift_sample,
    input  logic signed [DATA_W-1:0] i_rot_sample,
    input  logic signed [DATA_W-1:0] i_rot_coef,
    input  logic signed [DATA_W-1:0] i_load_coef,
    output logic signed [DATA_W-1:0] o_sample,
    output logic signed [DATA_W-1:0] o_coef
);

    logic signed [DATA_W-1:0] r_sample;
    logic signed [DATA_W-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
            r_coef   <= '0;
        end else begin
            if (i_ctrl.shift) begin
                r_sample <= i_shift_sample;
            end else if (i_ctrl.rotate) begin
                r_sample <= i_rot_sample;
            end
            if (i_ctrl.rotate) begin
                r_coef <= i_rot_coef;
            end else if (i_ctrl.load) begin
                r_coef <= i_load_coef;
            end
        end
    end

    assign o_sample = r_sample;
    assign o_coef   = r_coef;

endmodule

FILE: sv/fxfir_mac.sv
// ----------------------------------------------------------------------------
// fxfir_mac
// Shared multiply-accumulate: registered 32x32 product, then a 64-bit
// wrapping accumulate.
// ----------------------------------------------------------------------------
module fxfir_mac
    import fxfir_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [DATA_W-1:0] i_coef,
    input  logic signed [DATA_W-1:0] i_sample,
    output logic        [ACC_W-1:0]  o_acc
);

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] r_prod;
    logic                    r_prod_vld;
    logic        [ACC_W-1:0] r_acc;

    // full-width signed product
    assign prod = i_coef * i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.tap_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: sv/fixed_point_fir_filter.sv
// ----------------------------------------------------------------------------
// fixed_point_fir_filter
// Direct-form FIR filter, signed 32-bit samples, Q31 coefficients.
// ----------------------------------------------------------------------------
// A load transfer (mode 1) writes one coefficient and gives no result. A
// sample transfer (mode 0) shifts the sample into the row of tap cells and
// starts a pass: the row rotates once through the shared multiply-accumulate,
// one tap per cycle, the last product drains from the MAC product register
// into the accumulator, and the sum is then written to the output register;
// the pass holds while an earlier result still waits. The input is not ready
// during a pass. The result waits in an output register, and the next item
// is taken while it waits. tap_count is written on the configuration
// channel, which is always ready; it is 13 after reset and values above
// MAX_TAPS act as MAX_TAPS.
// ----------------------------------------------------------------------------
module fixed_point_fir_filter
    import fxfir_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic        [TAPS_W-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_mode,
    input  logic        [SLOT_W-1:0] i_coeff_slot,
    input  logic signed [DATA_W-1:0] i_data_word,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_out_sample
);

    localparam int CNTW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW    = $clog2(MAX_TAPS + 1);
    localparam int CW    = (TW > TAPS_W) ? TW : TAPS_W;
    localparam int SW    = (CNTW > SLOT_W) ? CNTW : SLOT_W;

    t_state              r_state;
    t_state              n_state;
    logic [CNTW-1:0]     r_cnt;
    logic [TAPS_W-1:0]   r_tap_count;
    logic                r_out_valid;
    logic signed [DATA_W-1:0] r_out_sample;

    logic                in_fire;
    logic                out_free;
    logic                cnt_last;
    logic [CW-1:0]       taps_eff;
    logic [SW-1:0]       slot_ext;
    t_mac_ctrl           mac_ctrl;
    logic                do_shift;
    logic                do_rotate;
    logic                do_load;
    logic [ACC_W-1:0]    acc;

    t_cell_ctrl               cell_ctrl [MAX_TAPS];
    logic signed [DATA_W-1:0] cell_sample [MAX_TAPS];
    logic signed [DATA_W-1:0] cell_coef   [MAX_TAPS];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign cnt_last    = (r_cnt == CNTW'(MAX_TAPS - 1));
    assign slot_ext    = SW'(i_coeff_slot);
    assign taps_eff    = (CW'(r_tap_count) > CW'(MAX_TAPS)) ? CW'(MAX_TAPS)
                                                             : CW'(r_tap_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tap_count <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_mode == MODE_SAMPLE) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        do_shift        = 1'b0;
        do_rotate       = 1'b0;
        do_load         = 1'b0;
        mac_ctrl.clear  = 1'b0;
        mac_ctrl.tap_en = 1'b0;
        case (r_state)
            ST_IDLE: begin
                do_shift       = in_fire && (i_mode == MODE_SAMPLE);
                do_load        = in_fire && (i_mode == MODE_LOAD);
                mac_ctrl.clear = do_shift;
            end
            ST_RUN: begin
                do_rotate       = 1'b1;
                mac_ctrl.tap_en = (CW'(r_cnt) < taps_eff);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RUN && !cnt_last) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_sample <= acc[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++) begin : g_cell
            logic signed [DATA_W-1:0] shift_src;

            assign cell_ctrl[k] = {do_shift, do_rotate,
                                   do_load && (slot_ext == SW'(k))};

            if (k == 0) begin : g_head
                assign shift_src = i_data_word;
            end else begin : g_body
                assign shift_src = cell_sample[k-1];
            end

            fxfir_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctrl         (cell_ctrl[k]),
                .i_shift_sample (shift_src),
                .i_rot_sample   (cell_sample[(k + 1) % MAX_TAPS]),
                .i_rot_coef     (cell_coef[(k + 1) % MAX_TAPS]),
                .i_load_coef    (i_data_word),
                .o_sample       (cell_sample[k]),
                .o_coef         (cell_coef[k])
            );
        end
    endgenerate

    fxfir_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_coef   (cell_coef[0]),
        .i_sample (cell_sample[0]),
        .o_acc    (acc)
    );

endmodule
